// ----- rtl/core/crce_pkg.sv -----
// ----------------------------------------------------------------------------
// crce_pkg
// Shared widths, codes, types and helper functions of the CLOCK evictor
// with per-slot reference counters.
// ----------------------------------------------------------------------------
package crce_pkg;

	// Table geometry
	localparam int MAX_DEVICES      = 4;
	localparam int SLOTS_PER_DEVICE = 1024;
	localparam int REF_CEILING      = 8;
	localparam int TABLE_DEPTH      = MAX_DEVICES * SLOTS_PER_DEVICE;
	localparam int IDX_W            = $clog2(TABLE_DEPTH);

	// Field widths
	localparam int DEV_W      = 2;
	localparam int SLOT_W     = 10;
	localparam int SLOT_CNT_W = 11;
	localparam int ARM_DEV_W  = 3;
	localparam int DEVCNT_W   = 3;
	localparam int REFS_W     = 4;
	localparam int LUN_W      = 8;
	localparam int FRAG_W     = 24;
	localparam int TOTAL_W    = 13;
	localparam int COUNT_W    = 13;
	localparam int STATUS_W   = 2;
	localparam int STEPS_W    = TOTAL_W + $clog2(REF_CEILING + 1);
	localparam int MAP_W      = LUN_W + FRAG_W;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_ADDR_W-1:0] CFG_DEVICE_COUNT = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_FRAGS_DEV0   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_FRAGS_DEV1   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_FRAGS_DEV2   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_FRAGS_DEV3   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_FRAGS  = 3'd5;

	// Request function codes
	localparam logic FUNC_EVICT = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_EVICTED = 2'd0,
		STATUS_NONE    = 2'd1,
		STATUS_WRITTEN = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_READ,
		ST_WR_UPDATE,
		ST_STEP,
		ST_MOD_WAIT,
		ST_EVAL,
		ST_DONE
	} state_t;

	// Per-slot marks kept in the flag table
	typedef struct packed {
		logic              in_use;
		logic              busy;
		logic [REFS_W-1:0] refs;
	} flags_t;

	localparam int FLAGS_W = $bits(flags_t);

	typedef struct packed {
		logic              func;
		logic [DEV_W-1:0]  dev_sel;
		logic [SLOT_W-1:0] slot_sel;
		logic              in_use;
		logic              busy_req;
		logic [REFS_W-1:0] ref_count;
		logic [LUN_W-1:0]  lun_index;
		logic [FRAG_W-1:0] mapped_frag;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [DEV_W-1:0]  victim_dev;
		logic [SLOT_W-1:0] victim_slot;
		logic [LUN_W-1:0]  victim_lun;
		logic [FRAG_W-1:0] victim_frag;
	} result_t;

	// Remainder unit control and status
	typedef struct packed {
		logic                  start;
		logic [SLOT_W-1:0]     dividend;
		logic [SLOT_CNT_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

	// Devices actually swept
	function automatic logic [DEVCNT_W-1:0] eff_devices(logic [DEVCNT_W-1:0] dc);
		return (dc > DEVCNT_W'(MAX_DEVICES)) ? DEVCNT_W'(MAX_DEVICES) : dc;
	endfunction

	// Slot count of a device, clamped to the table
	function automatic logic [SLOT_CNT_W-1:0] clamp_slots(logic [SLOT_CNT_W-1:0] v);
		return (v > SLOT_CNT_W'(SLOTS_PER_DEVICE)) ? SLOT_CNT_W'(SLOTS_PER_DEVICE) : v;
	endfunction

	// Arm device modulo the device count (count of one to four)
	function automatic logic [DEV_W-1:0] dev_mod(logic [ARM_DEV_W-1:0] a,
			logic [DEVCNT_W-1:0] n);
		logic [ARM_DEV_W-1:0] r;
		r = a;
		unique case (n)
			3'd1: r = '0;
			3'd2: r = {2'b00, a[0]};
			3'd3: begin
				if (r >= 3'd3) r = r - 3'd3;
				if (r >= 3'd3) r = r - 3'd3;
			end
			3'd4: r = {1'b0, a[1:0]};
			default: r = '0;
		endcase
		return r[DEV_W-1:0];
	endfunction

endpackage

// ----- rtl/core/crce_if.sv -----
// ----------------------------------------------------------------------------
// crce_req_if / crce_rsp_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface crce_req_if;
	import crce_pkg::*;

	logic              valid;
	logic              ready;
	logic              func;
	logic [DEV_W-1:0]  dev_sel;
	logic [SLOT_W-1:0] slot_sel;
	logic              in_use;
	logic              busy_req;
	logic [REFS_W-1:0] ref_count;
	logic [LUN_W-1:0]  lun_index;
	logic [FRAG_W-1:0] mapped_frag;

	modport source (
		output valid, func, dev_sel, slot_sel, in_use, busy_req, ref_count,
			lun_index, mapped_frag,
		input  ready
	);

	modport sink (
		input  valid, func, dev_sel, slot_sel, in_use, busy_req, ref_count,
			lun_index, mapped_frag,
		output ready
	);
endinterface

interface crce_rsp_if;
	import crce_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DEV_W-1:0]    victim_dev;
	logic [SLOT_W-1:0]   victim_slot;
	logic [LUN_W-1:0]    victim_lun;
	logic [FRAG_W-1:0]   victim_frag;

	modport source (
		output valid, status, victim_dev, victim_slot, victim_lun, victim_frag,
		input  ready
	);

	modport sink (
		input  valid, status, victim_dev, victim_slot, victim_lun, victim_frag,
		output ready
	);
endinterface

// ----- rtl/core/crce_ram.sv -----
// ----------------------------------------------------------------------------
// crce_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module crce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/crce_mod_unit.sv -----
// ----------------------------------------------------------------------------
// crce_mod_unit
// Restoring remainder unit: slot number modulo a device slot count,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crce_mod_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  crce_pkg::mod_req_t            req,
	output crce_pkg::mod_stat_t           stat,
	output logic [crce_pkg::SLOT_W-1:0]   rem
);
	import crce_pkg::*;

	localparam int CNT_W = $clog2(SLOT_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SLOT_W-1:0]     rem_q;
	logic [SLOT_W-1:0]     dvd_q;
	logic [SLOT_CNT_W-1:0] dsr_q;
	logic [SLOT_W:0]       trial;

	// Shift in the next dividend bit
	assign trial = {rem_q, dvd_q[SLOT_W-1]};

	// Control: count down the dividend bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start && !busy_q) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(SLOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: compare and subtract once per cycle
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SLOT_W-2:0], 1'b0};
			if (trial >= dsr_q) rem_q <= SLOT_W'(trial - dsr_q);
			else                rem_q <= trial[SLOT_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;
endmodule

// ----- rtl/core/clock_refcount_evictor_top.sv -----
// Write transaction: after acceptance the old marks are read, the entry is updated and
// the result is loaded. Evict transaction: each visited slot is placed and evaluated, a
// visit whose arm slot lies beyond its device's slot count first waits on the remainder
// unit, and with no slot in use the sweep is skipped; at most total_frags*8 visits.
// One transaction at a time; a result held on the output delays completion.
// Reset: a clearing pass zeroes all 4096 flag entries; configuration writes are taken.
// ----------------------------------------------------------------------------
// clock_refcount_evictor_top
// CLOCK replacement with per-slot reference counters over up to four cache
// devices: entry writes and sequenced eviction sweeps over a slot table.
// ----------------------------------------------------------------------------
module clock_refcount_evictor_top (
	input  logic                              clk,
	input  logic                              arst_n,
	crce_req_if.sink                          req,
	crce_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [crce_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [crce_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import crce_pkg::*;

	// Configuration registers
	logic [DEVCNT_W-1:0]   dev_count_q;
	logic [SLOT_CNT_W-1:0] frags_q [MAX_DEVICES];
	logic [TOTAL_W-1:0]    total_q;

	// Sequencer state
	state_t                state_q, state_d;
	logic [ARM_DEV_W-1:0]  arm_dev_q, arm_dev_d;
	logic [SLOT_W-1:0]     arm_slot_q, arm_slot_d;
	logic [STEPS_W-1:0]    steps_q, steps_d;
	logic [COUNT_W-1:0]    in_use_cnt_q, in_use_cnt_d;
	logic [IDX_W-1:0]      clr_idx_q;
	logic                  out_valid_q;

	// Payload registers
	item_t                 item_q, item_d;
	result_t               res_q, res_d, out_q;
	logic [DEV_W-1:0]      cur_dev_q, cur_dev_d;
	logic [SLOT_W-1:0]     cur_slot_q, cur_slot_d;

	// Table ports
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  fl_we;
	logic [IDX_W-1:0]      wr_addr;
	flags_t                fl_wdata;
	flags_t                fl_rdata;
	logic                  map_we;
	logic [MAP_W-1:0]      map_rdata;

	// Remainder unit
	mod_req_t              mod_req;
	mod_stat_t             mod_stat;
	logic [SLOT_W-1:0]     mod_rem;

	// Arm arithmetic
	logic [DEVCNT_W-1:0]   ndev;
	logic [DEV_W-1:0]      step_dev;
	logic [SLOT_CNT_W-1:0] step_nf;
	logic [SLOT_CNT_W-1:0] cur_nf;
	logic [SLOT_CNT_W-1:0] next_slot;
	logic                  evict_hit;
	logic                  out_load;

	assign ndev      = eff_devices(dev_count_q);
	assign step_dev  = dev_mod(arm_dev_q, ndev);
	assign step_nf   = clamp_slots(frags_q[step_dev]);
	assign cur_nf    = clamp_slots(frags_q[cur_dev_q]);
	assign next_slot = SLOT_CNT_W'(cur_slot_q) + SLOT_CNT_W'(1);
	assign evict_hit = fl_rdata.in_use && !fl_rdata.busy && (fl_rdata.refs == '0);

	crce_ram #(.WIDTH(FLAGS_W), .DEPTH(TABLE_DEPTH)) u_flags (
		.clk   (clk),
		.we    (fl_we),
		.waddr (wr_addr),
		.wdata (fl_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (fl_rdata)
	);

	crce_ram #(.WIDTH(MAP_W), .DEPTH(TABLE_DEPTH)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (wr_addr),
		.wdata ({item_q.lun_index, item_q.mapped_frag}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (map_rdata)
	);

	crce_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.stat   (mod_stat),
		.rem    (mod_rem)
	);

	// Next state and datapath control
	always_comb begin
		state_d      = state_q;
		arm_dev_d    = arm_dev_q;
		arm_slot_d   = arm_slot_q;
		steps_d      = steps_q;
		in_use_cnt_d = in_use_cnt_q;
		item_d       = item_q;
		res_d        = res_q;
		cur_dev_d    = cur_dev_q;
		cur_slot_d   = cur_slot_q;
		rd_en        = 1'b0;
		rd_addr      = {cur_dev_q, cur_slot_q};
		fl_we        = 1'b0;
		wr_addr      = {cur_dev_q, cur_slot_q};
		fl_wdata     = '0;
		map_we       = 1'b0;
		mod_req      = '{start: 1'b0, dividend: arm_slot_q, divisor: step_nf};
		out_load     = 1'b0;
		req.ready    = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				fl_we   = 1'b1;
				wr_addr = clr_idx_q;
				if (clr_idx_q == IDX_W'(TABLE_DEPTH - 1)) state_d = ST_IDLE;
			end

			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					item_d = '{func: req.func, dev_sel: req.dev_sel,
						slot_sel: req.slot_sel, in_use: req.in_use,
						busy_req: req.busy_req, ref_count: req.ref_count,
						lun_index: req.lun_index, mapped_frag: req.mapped_frag};
					res_d = '{status: STATUS_NONE, default: '0};
					if (req.func == FUNC_WRITE) begin
						state_d = ST_WR_READ;
					end else if (in_use_cnt_q == '0) begin
						state_d = ST_DONE;
					end else begin
						steps_d = STEPS_W'(total_q) * STEPS_W'(REF_CEILING);
						state_d = ST_STEP;
					end
				end
			end

			// Fetch old marks so the in-use count can follow the write
			ST_WR_READ: begin
				rd_en   = 1'b1;
				rd_addr = {item_q.dev_sel, item_q.slot_sel};
				state_d = ST_WR_UPDATE;
			end

			ST_WR_UPDATE: begin
				wr_addr  = {item_q.dev_sel, item_q.slot_sel};
				fl_we    = 1'b1;
				map_we   = 1'b1;
				fl_wdata = '{in_use: item_q.in_use, busy: item_q.busy_req,
					refs: item_q.ref_count};
				if (item_q.in_use && !fl_rdata.in_use)
					in_use_cnt_d = in_use_cnt_q + COUNT_W'(1);
				else if (!item_q.in_use && fl_rdata.in_use)
					in_use_cnt_d = in_use_cnt_q - COUNT_W'(1);
				res_d   = '{status: STATUS_WRITTEN, default: '0};
				state_d = ST_DONE;
			end

			// Place the arm and issue the table read or start the remainder unit
			ST_STEP: begin
				if (steps_q == '0 || ndev == '0) begin
					state_d = ST_DONE;
				end else begin
					steps_d = steps_q - STEPS_W'(1);
					if (step_nf == '0) begin
						// Empty device: hop to the next one and give up
						arm_dev_d = ARM_DEV_W'(step_dev) + ARM_DEV_W'(1);
						state_d   = ST_DONE;
					end else begin
						cur_dev_d = step_dev;
						if (SLOT_CNT_W'(arm_slot_q) < step_nf) begin
							cur_slot_d = arm_slot_q;
							rd_en      = 1'b1;
							rd_addr    = {step_dev, arm_slot_q};
							state_d    = ST_EVAL;
						end else begin
							mod_req.start = 1'b1;
							state_d       = ST_MOD_WAIT;
						end
					end
				end
			end

			// Wait for the arm slot remainder
			ST_MOD_WAIT: begin
				if (mod_stat.done) begin
					cur_slot_d = mod_rem;
					rd_en      = 1'b1;
					rd_addr    = {cur_dev_q, mod_rem};
					state_d    = ST_EVAL;
				end
			end

			// Advance the arm and act on the slot under it
			ST_EVAL: begin
				if (next_slot >= cur_nf) begin
					arm_slot_d = '0;
					arm_dev_d  = ARM_DEV_W'(cur_dev_q) + ARM_DEV_W'(1);
				end else begin
					arm_slot_d = next_slot[SLOT_W-1:0];
					arm_dev_d  = ARM_DEV_W'(cur_dev_q);
				end
				state_d = ST_STEP;
				if (fl_rdata.in_use && !fl_rdata.busy) begin
					fl_we = 1'b1;
					if (evict_hit) begin
						fl_wdata     = '0;
						in_use_cnt_d = in_use_cnt_q - COUNT_W'(1);
						res_d = '{status: STATUS_EVICTED, victim_dev: cur_dev_q,
							victim_slot: cur_slot_q,
							victim_lun: map_rdata[MAP_W-1:FRAG_W],
							victim_frag: map_rdata[FRAG_W-1:0]};
						state_d = ST_DONE;
					end else begin
						fl_wdata = '{in_use: 1'b1, busy: 1'b0,
							refs: fl_rdata.refs - REFS_W'(1)};
					end
				end
			end

			// Hand the result to the output register once it is free
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			arm_dev_q    <= '0;
			arm_slot_q   <= '0;
			steps_q      <= '0;
			in_use_cnt_q <= '0;
			clr_idx_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			arm_dev_q    <= arm_dev_d;
			arm_slot_q   <= arm_slot_d;
			steps_q      <= steps_d;
			in_use_cnt_q <= in_use_cnt_d;
			if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (out_load)       out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_count_q <= '0;
			total_q     <= '0;
			for (int i = 0; i < MAX_DEVICES; i++) frags_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_DEVICE_COUNT: dev_count_q <= cfg_data[DEVCNT_W-1:0];
				CFG_FRAGS_DEV0:   frags_q[0]  <= cfg_data[SLOT_CNT_W-1:0];
				CFG_FRAGS_DEV1:   frags_q[1]  <= cfg_data[SLOT_CNT_W-1:0];
				CFG_FRAGS_DEV2:   frags_q[2]  <= cfg_data[SLOT_CNT_W-1:0];
				CFG_FRAGS_DEV3:   frags_q[3]  <= cfg_data[SLOT_CNT_W-1:0];
				CFG_TOTAL_FRAGS:  total_q     <= cfg_data[TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		item_q     <= item_d;
		res_q      <= res_d;
		cur_dev_q  <= cur_dev_d;
		cur_slot_q <= cur_slot_d;
		if (out_load) out_q <= res_q;
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.victim_dev  = out_q.victim_dev;
	assign rsp.victim_slot = out_q.victim_slot;
	assign rsp.victim_lun  = out_q.victim_lun;
	assign rsp.victim_frag = out_q.victim_frag;

	// A slot is evaluated only after its table read was issued
	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> ($past(state_q) == ST_STEP ||
			$past(state_q) == ST_MOD_WAIT))
		else $error("slot evaluated without a table read");

	// The evaluated slot lies within its device
	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> SLOT_CNT_W'(cur_slot_q) < cur_nf)
		else $error("arm slot beyond device slot count");

	// An eviction drops the in-use count by one
	a_evict_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && evict_hit) |=>
			in_use_cnt_q == $past(in_use_cnt_q) - COUNT_W'(1))
		else $error("in-use count not decremented on eviction");

	// The remainder unit is running or finished while the sequencer waits
	a_mod_alive: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD_WAIT |-> (mod_stat.busy || mod_stat.done))
		else $error("waiting on an idle remainder unit");

	// A result appears only out of the completion state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside completion");
endmodule
